// ----- design/djb_pkg.sv -----
// ----------------------------------------------------------------------------
// djb_pkg: shared types and constants for the djb2 hash table insert block
// Hash constants, sequencer states and the slot store control structs.
// ----------------------------------------------------------------------------
package djb_pkg;

    localparam int HASH_BITS = 32;
    localparam int BYTE_BITS = 8;
    localparam int HASH_SHIFT = 5;
    localparam logic [HASH_BITS-1:0] HASH_SEED = 32'd5381;

    typedef enum logic [2:0] {
        ST_CLEAR,   // slot store sweep after reset
        ST_HASH,    // taking key bytes
        ST_ABS,     // magnitude of the final hash, start reduction
        ST_MOD,     // modulo reduction running
        ST_RD,      // read the probed slot
        ST_CHK      // check the slot, store or move on
    } state_t;

    typedef struct packed {
        logic rd;   // read slot at address
        logic wr;   // mark slot valid and store owner
    } mem_ctl_t;

    typedef struct packed {
        logic clearing;
    } mem_stat_t;

endpackage

// ----- design/djb_if.sv -----
// ----------------------------------------------------------------------------
// djb_if: valid/ready channels of the djb2 hash table insert block
// Key byte request channel and insert result channel.
// ----------------------------------------------------------------------------
interface djb_key_if #(
    parameter int ID_BITS = 16
);
    logic                 valid;
    logic                 ready;
    logic [7:0]           key_byte;
    logic                 last_byte;
    logic [ID_BITS-1:0]   entry_id;

    modport source (output valid, output key_byte, output last_byte, output entry_id,
                    input ready);
    modport sink   (input valid, input key_byte, input last_byte, input entry_id,
                    output ready);
endinterface

interface djb_res_if #(
    parameter int SLOT_BITS = 10,
    parameter int CNT_BITS  = 11
);
    logic                  valid;
    logic                  ready;
    logic [SLOT_BITS-1:0]  slot_index;
    logic                  table_full;
    logic [CNT_BITS-1:0]   probe_count;

    modport source (output valid, output slot_index, output table_full, output probe_count,
                    input ready);
    modport sink   (input valid, input slot_index, input table_full, input probe_count,
                    output ready);
endinterface

// ----- design/djb_reduce.sv -----
// ----------------------------------------------------------------------------
// djb_reduce: modulo unit for the table size
// Remainder by a scaled reciprocal multiply, then a fold step.
// ----------------------------------------------------------------------------
module djb_reduce #(
    parameter int TABLE_SLOTS = 1024
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic [djb_pkg::HASH_BITS-1:0]          value,
    output logic                                   done,
    output logic [$clog2(TABLE_SLOTS)-1:0]         rem
);
    localparam int SLOT_BITS  = $clog2(TABLE_SLOTS);
    localparam int HB         = djb_pkg::HASH_BITS;
    localparam int SHIFT      = HB + SLOT_BITS;
    localparam int RECIP_BITS = HB + 1;
    localparam int PROD_BITS  = HB + RECIP_BITS;
    // ceil(2^SHIFT / TABLE_SLOTS): quotient is exact for every 32-bit value
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(TABLE_SLOTS) - 64'd1) / 64'(TABLE_SLOTS);
    localparam logic [RECIP_BITS-1:0] RECIP   = RECIP_BITS'(RECIP_FULL);
    localparam logic [SLOT_BITS-1:0]  MOD_LOW = SLOT_BITS'(TABLE_SLOTS);

    logic                           busy_reg, busy_next;
    logic                           phase_reg, phase_next;
    logic                           done_reg, done_next;
    logic [HB-1:0]                  val_reg, val_next;
    logic [PROD_BITS-1:0]           prod_reg, prod_next;
    logic [SLOT_BITS-1:0]           rem_reg, rem_next;

    always_comb
    begin
        busy_next  = busy_reg;
        phase_next = phase_reg;
        done_next  = 1'b0;
        val_next   = val_reg;
        prod_next  = prod_reg;
        rem_next   = rem_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            phase_next = 1'b0;
            val_next   = value;
        end
        else if (busy_reg)
        begin
            if (!phase_reg)
            begin
                // quotient sits in the bits from SHIFT up
                prod_next  = PROD_BITS'(val_reg) * PROD_BITS'(RECIP);
                phase_next = 1'b1;
            end
            else
            begin
                // remainder < TABLE_SLOTS, low bits of value - q * M suffice
                rem_next  = val_reg[SLOT_BITS-1:0]
                          - prod_reg[SHIFT +: SLOT_BITS] * MOD_LOW;
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            phase_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg  <= val_next;
        prod_reg <= prod_next;
        rem_reg  <= rem_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

// ----- design/djb_slot_mem.sv -----
// ----------------------------------------------------------------------------
// djb_slot_mem: slot valid and owner memories
// Valid bits are swept to zero after reset; owner store is never cleared.
// ----------------------------------------------------------------------------
module djb_slot_mem #(
    parameter int TABLE_SLOTS = 1024,
    parameter int ID_BITS     = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  djb_pkg::mem_ctl_t                 ctl,
    input  logic [$clog2(TABLE_SLOTS)-1:0]    addr,
    input  logic [ID_BITS-1:0]                wr_owner,
    output djb_pkg::mem_stat_t                stat,
    output logic                              rd_valid,
    output logic [ID_BITS-1:0]                rd_owner
);
    localparam int SLOT_BITS = $clog2(TABLE_SLOTS);
    localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(TABLE_SLOTS - 1);

    logic                  valid_mem [TABLE_SLOTS];
    logic [ID_BITS-1:0]    owner_mem [TABLE_SLOTS];

    logic                  clearing_reg, clearing_next;
    logic [SLOT_BITS-1:0]  clr_addr_reg, clr_addr_next;
    logic                  rd_valid_reg;
    logic [ID_BITS-1:0]    rd_owner_reg;

    always_comb
    begin
        clearing_next = clearing_reg;
        clr_addr_next = clr_addr_reg;
        if (clearing_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == LAST_SLOT)
                clearing_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else
        begin
            clearing_reg <= clearing_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clearing_reg)
            valid_mem[clr_addr_reg] <= 1'b0;
        else if (ctl.wr)
            valid_mem[addr] <= 1'b1;
        if (ctl.rd)
            rd_valid_reg <= valid_mem[addr];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.wr)
            owner_mem[addr] <= wr_owner;
        if (ctl.rd)
            rd_owner_reg <= owner_mem[addr];
    end

    assign stat.clearing = clearing_reg;
    assign rd_valid      = rd_valid_reg;
    assign rd_owner      = rd_owner_reg;

endmodule

// ----- design/djb2_hash_table_insert.sv -----
// ----------------------------------------------------------------------------
// djb2_hash_table_insert: djb2 hash with linear probing insert
// Hashes key bytes, reduces by the table size and probes for a free slot.
// ----------------------------------------------------------------------------
// Usage:
//   key    : valid/ready request channel, one key byte per request with a
//            last_byte mark and the entry handle (taken from the last byte).
//   result : valid/ready channel, one result per key: slot_index, table_full
//            and probe_count.
// Throughput: bytes that are not last are taken one per cycle, the running
//   hash is a single shift-add. After a last byte key is not ready while
//   the block takes the magnitude, reduces it (reciprocal multiply, fold,
//   hand-off) and probes slots, each probe a registered read of the slot
//   memories and then a check. The result is shown the cycle after the
//   matching slot is checked. A full table ends after every slot is probed.
// Reset: the hash returns to 5381 and a sweep clears the valid bit of every
//   slot, one per cycle, with key not ready until the sweep is done.
// Stalls: the result sits in an output register. While it waits, new key
//   bytes are still taken; the next insert holds at its check step until the
//   register is free.
// ----------------------------------------------------------------------------
module djb2_hash_table_insert #(
    parameter int TABLE_SLOTS = 1024,
    parameter int ID_BITS     = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    djb_key_if.sink    key,
    djb_res_if.source  result
);
    localparam int SLOT_BITS = $clog2(TABLE_SLOTS);
    localparam int CNT_BITS  = $clog2(TABLE_SLOTS + 1);
    localparam int HB        = djb_pkg::HASH_BITS;
    localparam logic [SLOT_BITS-1:0] LAST_SLOT  = SLOT_BITS'(TABLE_SLOTS - 1);
    localparam logic [CNT_BITS-1:0]  LAST_PROBE = CNT_BITS'(TABLE_SLOTS - 1);
    localparam logic [CNT_BITS-1:0]  FULL_COUNT = CNT_BITS'(TABLE_SLOTS);

    djb_pkg::state_t     state_reg, state_next;
    logic [HB-1:0]       hash_reg, hash_next;
    logic [ID_BITS-1:0]  id_reg, id_next;
    logic [SLOT_BITS-1:0] slot_reg, slot_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;

    // output register
    logic                 out_valid_reg, out_valid_next;
    logic [SLOT_BITS-1:0] out_slot_reg, out_slot_next;
    logic                 out_full_reg, out_full_next;
    logic [CNT_BITS-1:0]  out_cnt_reg, out_cnt_next;

    logic                 out_free;
    logic                 hit;
    logic [HB-1:0]        magnitude;
    logic                 red_start;
    logic                 red_done;
    logic [SLOT_BITS-1:0] red_rem;

    djb_pkg::mem_ctl_t    mem_ctl;
    djb_pkg::mem_stat_t   mem_stat;
    logic                 rd_valid;
    logic [ID_BITS-1:0]   rd_owner;

    djb_reduce #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_reduce (
        .clk   (clk),
        .rst_n (rst_n),
        .start (red_start),
        .value (magnitude),
        .done  (red_done),
        .rem   (red_rem)
    );

    djb_slot_mem #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .ID_BITS     (ID_BITS)
    ) u_slot_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (mem_ctl),
        .addr     (slot_reg),
        .wr_owner (id_reg),
        .stat     (mem_stat),
        .rd_valid (rd_valid),
        .rd_owner (rd_owner)
    );

    // absolute value; the most negative hash wraps to itself
    assign magnitude = hash_reg[HB-1] ? (HB'(0) - hash_reg) : hash_reg;
    assign out_free  = !out_valid_reg || result.ready;
    // a slot is usable when empty or already owned by this handle
    assign hit       = !rd_valid || (rd_owner == id_reg);

    always_comb
    begin
        state_next     = state_reg;
        hash_next      = hash_reg;
        id_next        = id_reg;
        slot_next      = slot_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_slot_next  = out_slot_reg;
        out_full_next  = out_full_reg;
        out_cnt_next   = out_cnt_reg;
        red_start      = 1'b0;
        mem_ctl        = '0;
        key.ready      = 1'b0;

        case (state_reg)
            djb_pkg::ST_CLEAR:
            begin
                if (!mem_stat.clearing)
                    state_next = djb_pkg::ST_HASH;
            end
            djb_pkg::ST_HASH:
            begin
                key.ready = 1'b1;
                if (key.valid)
                begin
                    // hash * 33 + byte
                    hash_next = (hash_reg << djb_pkg::HASH_SHIFT) + hash_reg
                              + HB'(key.key_byte);
                    if (key.last_byte)
                    begin
                        id_next    = key.entry_id;
                        state_next = djb_pkg::ST_ABS;
                    end
                end
            end
            djb_pkg::ST_ABS:
            begin
                red_start  = 1'b1;
                hash_next  = djb_pkg::HASH_SEED;
                state_next = djb_pkg::ST_MOD;
            end
            djb_pkg::ST_MOD:
            begin
                if (red_done)
                begin
                    slot_next  = red_rem;
                    cnt_next   = '0;
                    state_next = djb_pkg::ST_RD;
                end
            end
            djb_pkg::ST_RD:
            begin
                mem_ctl.rd = 1'b1;
                state_next = djb_pkg::ST_CHK;
            end
            djb_pkg::ST_CHK:
            begin
                if (hit)
                begin
                    if (out_free)
                    begin
                        mem_ctl.wr     = 1'b1;
                        out_valid_next = 1'b1;
                        out_slot_next  = slot_reg;
                        out_full_next  = 1'b0;
                        out_cnt_next   = cnt_reg;
                        state_next     = djb_pkg::ST_HASH;
                    end
                end
                else if (cnt_reg == LAST_PROBE)
                begin
                    // every slot taken by another handle
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_slot_next  = '0;
                        out_full_next  = 1'b1;
                        out_cnt_next   = FULL_COUNT;
                        state_next     = djb_pkg::ST_HASH;
                    end
                end
                else
                begin
                    cnt_next   = cnt_reg + 1'b1;
                    slot_next  = (slot_reg == LAST_SLOT) ? '0 : slot_reg + 1'b1;
                    state_next = djb_pkg::ST_RD;
                end
            end
            default:
            begin
                state_next = djb_pkg::ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= djb_pkg::ST_CLEAR;
            hash_reg      <= djb_pkg::HASH_SEED;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hash_reg      <= hash_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg       <= id_next;
        slot_reg     <= slot_next;
        cnt_reg      <= cnt_next;
        out_slot_reg <= out_slot_next;
        out_full_reg <= out_full_next;
        out_cnt_reg  <= out_cnt_next;
    end

    assign result.valid       = out_valid_reg;
    assign result.slot_index  = out_slot_reg;
    assign result.table_full  = out_full_reg;
    assign result.probe_count = out_cnt_reg;

endmodule

// ----- design/djb_checker.sv -----
// ----------------------------------------------------------------------------
// djb_checker: port-level checks for djb2_hash_table_insert
// Result hold under stall and key channel pacing around inserts.
// ----------------------------------------------------------------------------
module djb_checker #(
    parameter int TABLE_SLOTS = 1024
) (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            key_valid,
    input logic                            key_ready,
    input logic                            key_last,
    input logic                            res_valid,
    input logic                            res_ready,
    input logic [$clog2(TABLE_SLOTS)-1:0]  slot_index,
    input logic                            table_full,
    input logic [$clog2(TABLE_SLOTS+1)-1:0] probe_count
);

    // stalled result holds its payload
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(slot_index)
            && $stable(table_full) && $stable(probe_count))
        else $error("result changed while stalled");

    // a byte that is not last never stalls the key channel
    a_byte_rate: assert property (@(posedge clk) disable iff (!rst_n)
        key_valid && key_ready && !key_last |=> key_ready)
        else $error("key channel stalled after a plain byte");

    // the insert walk holds off the key channel
    a_insert_busy: assert property (@(posedge clk) disable iff (!rst_n)
        key_valid && key_ready && key_last |=> !key_ready)
        else $error("key taken during insert");

    // a new result only comes out of an insert walk
    a_res_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> !$past(key_ready))
        else $error("result without an insert");

endmodule

bind djb2_hash_table_insert djb_checker #(
    .TABLE_SLOTS (TABLE_SLOTS)
) u_djb_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .key_valid   (key.valid),
    .key_ready   (key.ready),
    .key_last    (key.last_byte),
    .res_valid   (result.valid),
    .res_ready   (result.ready),
    .slot_index  (result.slot_index),
    .table_full  (result.table_full),
    .probe_count (result.probe_count)
);
